>>> design/nmea_gga_pkg.sv
// Package for the GGA sentence parser: header state type, ASCII codes,
// field numbers and the decimal accumulate helper.
// Depends on nothing.
package nmea_gga_pkg;

  typedef enum logic [2:0] {
    HDR_HUNT   = 3'd0,
    HDR_DOLLAR = 3'd1,
    HDR_G      = 3'd2,
    HDR_GP     = 3'd3,
    HDR_GPG    = 3'd4,
    HDR_GPGG   = 3'd5,
    HDR_BODY   = 3'd6
  } hdr_state_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_HOUR,
    ACC_MINUTE,
    ACC_SECOND,
    ACC_LAT_DEG,
    ACC_LAT_MIN,
    ACC_LON_DEG,
    ACC_LON_MIN
  } acc_sel_e;

  localparam logic [7:0] ASCII_DOLLAR = 8'h24;
  localparam logic [7:0] ASCII_G      = 8'h47;
  localparam logic [7:0] ASCII_P      = 8'h50;
  localparam logic [7:0] ASCII_A      = 8'h41;
  localparam logic [7:0] ASCII_CR     = 8'h0D;
  localparam logic [7:0] ASCII_COMMA  = 8'h2C;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_NINE   = 8'h39;
  localparam logic [7:0] ASCII_S      = 8'h53;

  localparam logic [3:0] FLD_TIME = 4'd1;
  localparam logic [3:0] FLD_LAT  = 4'd2;
  localparam logic [3:0] FLD_NS   = 4'd3;
  localparam logic [3:0] FLD_LON  = 4'd4;
  localparam logic [3:0] FLD_QUAL = 4'd6;
  localparam logic [3:0] CNT_MAX  = 4'd15;

  localparam logic [4:0] HOUR_OFFSET_RST = 5'd9;
  localparam logic [4:0] HOURS_PER_DAY   = 5'd24;
  localparam logic [4:0] HOUR_MAX        = 5'd23;

  // acc * 10 + d, truncated to 20 bits.
  function automatic logic [19:0] mac10(input logic [19:0] acc, input logic [3:0] d);
    return (acc << 3) + (acc << 1) + {16'd0, d};
  endfunction

endpackage

>>> design/nmea_gga_sentence_parser_core.sv
// Top level of the GGA sentence parser: header match, field counting,
// digit accumulation and the result register.
// Depends on nmea_gga_pkg.

// The parser takes one received character per clock cycle: each byte passes
// a compare and a multiply-by-ten accumulate on its way into the state
// registers. After "$GPGGA" has been seen, a carriage return produces one
// result in the cycle after it is accepted; no other byte produces a result.
// The input is held off only while a finished result waits in the result
// register and the downstream side is not taking it. hour_offset is to be
// written through cfg_we_i and cfg_wdata_i only while the parser is idle;
// the block itself does not enforce this.
module nmea_gga_sentence_parser_core
  import nmea_gga_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [4:0]        cfg_wdata_i,
  input  logic              rx_valid_i,
  output logic              rx_ready_o,
  input  logic [7:0]        rx_byte_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output logic              fix_ok_o,
  output logic [4:0]        hour_o,
  output logic [6:0]        minute_o,
  output logic [6:0]        second_o,
  output logic signed [7:0] lat_degrees_o,
  output logic [19:0]       lat_minutes_e4_o,
  output logic [9:0]        lon_degrees_o,
  output logic [19:0]       lon_minutes_e4_o
);

  hdr_state_e  hdr_q, hdr_d;
  logic [4:0]  hour_offset_q;
  logic [3:0]  field_q, field_d;
  logic [3:0]  pos_q, pos_d;
  logic        stopped_q, stopped_d;
  logic [6:0]  hour_acc_q, hour_acc_d;
  logic [6:0]  minute_acc_q, minute_acc_d;
  logic [6:0]  second_acc_q, second_acc_d;
  logic [6:0]  lat_deg_q, lat_deg_d;
  logic [19:0] lat_min_q, lat_min_d;
  logic [9:0]  lon_deg_q, lon_deg_d;
  logic [19:0] lon_min_q, lon_min_d;
  logic        south_q, south_d;
  logic        no_fix_q, no_fix_d;

  logic        res_valid_q, res_valid_d;
  logic        fix_ok_q;
  logic [4:0]  hour_q;
  logic [6:0]  minute_q, second_q;
  logic [7:0]  lat_degrees_q;
  logic [19:0] lat_minutes_q;
  logic [9:0]  lon_degrees_q;
  logic [19:0] lon_minutes_q;

  logic        accept;
  logic        emit;
  logic        is_digit;
  logic [3:0]  dval;
  acc_sel_e    sel;
  logic        first;
  logic        stop_eff;
  logic [4:0]  hour_clamp;
  logic [4:0]  offset_mod;
  logic [5:0]  hour_sum;
  logic [4:0]  hour_local;
  logic [7:0]  lat_signed;

  assign rx_ready_o = !res_valid_q || res_ready_i;
  assign accept     = rx_valid_i && rx_ready_o;
  assign is_digit   = (rx_byte_i >= ASCII_ZERO) && (rx_byte_i <= ASCII_NINE);
  assign dval       = rx_byte_i[3:0];
  assign emit       = accept && (hdr_q == HDR_BODY) && (rx_byte_i == ASCII_CR);

  // Which accumulator the current character feeds, and whether it opens a number.
  always_comb begin
    sel   = ACC_NONE;
    first = 1'b0;
    case (field_q)
      FLD_TIME: begin
        if (pos_q < 4'd2) begin
          sel   = ACC_HOUR;
          first = (pos_q == 4'd0);
        end else if (pos_q < 4'd4) begin
          sel   = ACC_MINUTE;
          first = (pos_q == 4'd2);
        end else if (pos_q < 4'd6) begin
          sel   = ACC_SECOND;
          first = (pos_q == 4'd4);
        end
      end
      FLD_LAT: begin
        if (pos_q < 4'd2) begin
          sel   = ACC_LAT_DEG;
          first = (pos_q == 4'd0);
        end else if (pos_q == 4'd2 || pos_q == 4'd3 || (pos_q >= 4'd5 && pos_q <= 4'd8)) begin
          sel   = ACC_LAT_MIN;
          first = (pos_q == 4'd2);
        end
      end
      FLD_LON: begin
        if (pos_q < 4'd3) begin
          sel   = ACC_LON_DEG;
          first = (pos_q == 4'd0);
        end else if (pos_q == 4'd3 || pos_q == 4'd4 || (pos_q >= 4'd6 && pos_q <= 4'd9)) begin
          sel   = ACC_LON_MIN;
          first = (pos_q == 4'd3);
        end
      end
      default: begin
        sel   = ACC_NONE;
        first = 1'b0;
      end
    endcase
  end

  assign stop_eff = first ? 1'b0 : stopped_q;

  // Header matching and body parsing.
  always_comb begin
    hdr_d        = hdr_q;
    field_d      = field_q;
    pos_d        = pos_q;
    stopped_d    = stopped_q;
    hour_acc_d   = hour_acc_q;
    minute_acc_d = minute_acc_q;
    second_acc_d = second_acc_q;
    lat_deg_d    = lat_deg_q;
    lat_min_d    = lat_min_q;
    lon_deg_d    = lon_deg_q;
    lon_min_d    = lon_min_q;
    south_d      = south_q;
    no_fix_d     = no_fix_q;
    if (accept) begin
      case (hdr_q)
        HDR_HUNT:   hdr_d = (rx_byte_i == ASCII_DOLLAR) ? HDR_DOLLAR : HDR_HUNT;
        HDR_DOLLAR: hdr_d = (rx_byte_i == ASCII_G) ? HDR_G : HDR_HUNT;
        HDR_G:      hdr_d = (rx_byte_i == ASCII_P) ? HDR_GP : HDR_HUNT;
        HDR_GP:     hdr_d = (rx_byte_i == ASCII_G) ? HDR_GPG : HDR_HUNT;
        HDR_GPG:    hdr_d = (rx_byte_i == ASCII_G) ? HDR_GPGG : HDR_HUNT;
        HDR_GPGG:   hdr_d = (rx_byte_i == ASCII_A) ? HDR_BODY : HDR_HUNT;
        HDR_BODY: begin
          if (rx_byte_i == ASCII_CR) begin
            // End of sentence: everything starts over.
            hdr_d        = HDR_HUNT;
            field_d      = '0;
            pos_d        = '0;
            stopped_d    = 1'b0;
            hour_acc_d   = '0;
            minute_acc_d = '0;
            second_acc_d = '0;
            lat_deg_d    = '0;
            lat_min_d    = '0;
            lon_deg_d    = '0;
            lon_min_d    = '0;
            south_d      = 1'b0;
            no_fix_d     = 1'b0;
          end else if (rx_byte_i == ASCII_COMMA) begin
            if (field_q != CNT_MAX) field_d = field_q + 4'd1;
            pos_d     = '0;
            stopped_d = 1'b0;
          end else begin
            if (sel != ACC_NONE) begin
              stopped_d = stop_eff | ~is_digit;
              if (!stop_eff && is_digit) begin
                case (sel)
                  ACC_HOUR:    hour_acc_d   = 7'(mac10({13'd0, hour_acc_q}, dval));
                  ACC_MINUTE:  minute_acc_d = 7'(mac10({13'd0, minute_acc_q}, dval));
                  ACC_SECOND:  second_acc_d = 7'(mac10({13'd0, second_acc_q}, dval));
                  ACC_LAT_DEG: lat_deg_d    = 7'(mac10({13'd0, lat_deg_q}, dval));
                  ACC_LAT_MIN: lat_min_d    = mac10(lat_min_q, dval);
                  ACC_LON_DEG: lon_deg_d    = 10'(mac10({10'd0, lon_deg_q}, dval));
                  ACC_LON_MIN: lon_min_d    = mac10(lon_min_q, dval);
                  default:     hour_acc_d   = hour_acc_q;
                endcase
              end
            end
            if (field_q == FLD_NS && pos_q == 4'd0) south_d = (rx_byte_i == ASCII_S);
            if (field_q == FLD_QUAL && pos_q == 4'd0) no_fix_d = (rx_byte_i == ASCII_ZERO);
            if (pos_q != CNT_MAX) pos_d = pos_q + 4'd1;
          end
        end
        default: hdr_d = HDR_HUNT;
      endcase
    end
  end

  // Local hour: clamp to 23, then subtract the offset modulo 24.
  always_comb begin
    hour_clamp = (hour_acc_q > {2'd0, HOUR_MAX}) ? HOUR_MAX : hour_acc_q[4:0];
    offset_mod = (hour_offset_q >= HOURS_PER_DAY) ? hour_offset_q - HOURS_PER_DAY
                                                  : hour_offset_q;
    hour_sum   = {1'b0, hour_clamp} + {1'b0, HOURS_PER_DAY} - {1'b0, offset_mod};
    hour_local = (hour_sum >= {1'b0, HOURS_PER_DAY}) ? hour_sum[4:0] - HOURS_PER_DAY
                                                     : hour_sum[4:0];
    lat_signed = south_q ? (8'd0 - {1'b0, lat_deg_q}) : {1'b0, lat_deg_q};
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (emit) res_valid_d = 1'b1;
    else if (res_ready_i) res_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= HDR_HUNT;
    end else begin
      hdr_q <= hdr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_offset_q <= HOUR_OFFSET_RST;
      field_q       <= '0;
      pos_q         <= '0;
      stopped_q     <= 1'b0;
      hour_acc_q    <= '0;
      minute_acc_q  <= '0;
      second_acc_q  <= '0;
      lat_deg_q     <= '0;
      lat_min_q     <= '0;
      lon_deg_q     <= '0;
      lon_min_q     <= '0;
      south_q       <= 1'b0;
      no_fix_q      <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) hour_offset_q <= cfg_wdata_i;
      field_q      <= field_d;
      pos_q        <= pos_d;
      stopped_q    <= stopped_d;
      hour_acc_q   <= hour_acc_d;
      minute_acc_q <= minute_acc_d;
      second_acc_q <= second_acc_d;
      lat_deg_q    <= lat_deg_d;
      lat_min_q    <= lat_min_d;
      lon_deg_q    <= lon_deg_d;
      lon_min_q    <= lon_min_d;
      south_q      <= south_d;
      no_fix_q     <= no_fix_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Result payload; a sentence without a fix reports all zeros.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      fix_ok_q      <= !no_fix_q;
      hour_q        <= no_fix_q ? '0 : hour_local;
      minute_q      <= no_fix_q ? '0 : minute_acc_q;
      second_q      <= no_fix_q ? '0 : second_acc_q;
      lat_degrees_q <= no_fix_q ? '0 : lat_signed;
      lat_minutes_q <= no_fix_q ? '0 : lat_min_q;
      lon_degrees_q <= no_fix_q ? '0 : lon_deg_q;
      lon_minutes_q <= no_fix_q ? '0 : lon_min_q;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign fix_ok_o         = fix_ok_q;
  assign hour_o           = hour_q;
  assign minute_o         = minute_q;
  assign second_o         = second_q;
  assign lat_degrees_o    = $signed(lat_degrees_q);
  assign lat_minutes_e4_o = lat_minutes_q;
  assign lon_degrees_o    = lon_degrees_q;
  assign lon_minutes_e4_o = lon_minutes_q;

endmodule
